[design/cshs_pkg.sv]
`timescale 1ns / 1ps
package cshs_pkg;

  localparam int NORM_W = 16;
  localparam int BIT_W  = 17;
  // tangent after rounding, wide enough for the smallest fraction width
  localparam int TAN_W  = 25;
  localparam int CW     = 34;
  localparam int OUT_W  = 16;

  localparam logic [31:0]          PI_Q30   = 32'd3373259426;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic [2:0][NORM_W-1:0] n;
    logic [2:0][BIT_W-1:0]  b;
    logic [2:0][TAN_W-1:0]  t;
    logic [1:0]             quad;
  } frame_t;

  // arctangent of 2^-i in Q30, floored up to i = 26 and rounded above
  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] v;
    case (idx)
      0: v = 32'd843314856;
      1: v = 32'd497837829;
      2: v = 32'd263043836;
      3: v = 32'd133525158;
      4: v = 32'd67021686;
      5: v = 32'd33543515;
      6: v = 32'd16775850;
      7: v = 32'd8388437;
      8: v = 32'd4194282;
      9: v = 32'd2097149;
      10: v = 32'd1048575;
      11: v = 32'd524287;
      12: v = 32'd262143;
      13: v = 32'd131071;
      14: v = 32'd65535;
      15: v = 32'd32767;
      16: v = 32'd16383;
      17: v = 32'd8191;
      18: v = 32'd4095;
      19: v = 32'd2047;
      20: v = 32'd1023;
      21: v = 32'd511;
      22: v = 32'd255;
      23: v = 32'd127;
      24: v = 32'd63;
      25: v = 32'd31;
      26: v = 32'd15;
      27: v = 32'd8;
      28: v = 32'd4;
      29: v = 32'd2;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

[design/cshs_cell.sv]
`timescale 1ns / 1ps
module cshs_cell
  import cshs_pkg::*;
#(
  parameter int IDX          = 0,
  parameter int FRAC_BITS    = 14,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_vld,
  input  frame_t                   in_frame,
  input  logic signed [CW-1:0]     in_x,
  input  logic signed [CW-1:0]     in_y,
  input  logic signed [CW-1:0]     in_z,
  input  logic [2*FRAC_BITS:0]     in_rv,
  input  logic [2*FRAC_BITS:0]     in_rr,
  input  logic [2*FRAC_BITS:0]     in_hv,
  input  logic [2*FRAC_BITS:0]     in_hr,
  output logic                     out_vld,
  output frame_t                   out_frame,
  output logic signed [CW-1:0]     out_x,
  output logic signed [CW-1:0]     out_y,
  output logic signed [CW-1:0]     out_z,
  output logic [2*FRAC_BITS:0]     out_rv,
  output logic [2*FRAC_BITS:0]     out_rr,
  output logic [2*FRAC_BITS:0]     out_hv,
  output logic [2*FRAC_BITS:0]     out_hr
);

  localparam int QW       = 2 * FRAC_BITS + 1;
  localparam int SQ_STEPS = FRAC_BITS + 1;
  localparam int SQ_SH    = (IDX < SQ_STEPS) ? 2 * FRAC_BITS - 2 * IDX : 0;
  localparam logic [QW-1:0] SQ_BIT = QW'(1) << SQ_SH;
  localparam logic signed [CW-1:0] ATAN = $signed({2'b00, atan_q30(IDX)});

  logic signed [CW-1:0] x_next, y_next, z_next;
  logic [QW-1:0] rv_next, rr_next, hv_next, hr_next;

  // one digit of the restoring square root
  function automatic logic [2*QW-1:0] sq_step(input logic [QW-1:0] v,
                                              input logic [QW-1:0] res);
    logic [QW-1:0] trial;
    trial = res + SQ_BIT;
    if (v >= trial) return {v - trial, (res >> 1) + SQ_BIT};
    return {v, res >> 1};
  endfunction

  always_comb begin
    x_next = in_x;
    y_next = in_y;
    z_next = in_z;
    if (IDX < CORDIC_STEPS) begin
      if (in_z >= 0) begin
        x_next = in_x - (in_y >>> IDX);
        y_next = in_y + (in_x >>> IDX);
        z_next = in_z - ATAN;
      end else begin
        x_next = in_x + (in_y >>> IDX);
        y_next = in_y - (in_x >>> IDX);
        z_next = in_z + ATAN;
      end
    end
    {rv_next, rr_next} = {in_rv, in_rr};
    {hv_next, hr_next} = {in_hv, in_hr};
    if (IDX < SQ_STEPS) begin
      {rv_next, rr_next} = sq_step(in_rv, in_rr);
      {hv_next, hr_next} = sq_step(in_hv, in_hr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_frame <= in_frame;
      out_x     <= x_next;
      out_y     <= y_next;
      out_z     <= z_next;
      out_rv    <= rv_next;
      out_rr    <= rr_next;
      out_hv    <= hv_next;
      out_hr    <= hr_next;
    end
  end

endmodule

[design/cosine_hemisphere_sampler.sv]
`timescale 1ns / 1ps
// Cosine-weighted hemisphere sampler.
// Input channel (in_valid / in_stall): one word per sample with a Q1.14 surface
// normal and two uniform fractions. A word is taken on an edge with in_valid
// high and in_stall low. Output channel (out_valid / out_stall): one direction
// word per input word, in order, Q1.14, each component saturated to +-1.0.
// Throughput: one word per cycle while in_stall is low. The rate is set by the
// cell row: each cell does at most one CORDIC rotation and one root digit for
// both square roots and hands its word to the next cell each cycle the pipe advances.
// Stages: one frame stage, the cell row, four combine stages and the output register.
// Stall: the output register is backed by a one-word skid. While the skid is
// empty the whole pipe keeps moving even if out_stall is high; in_stall rises
// only once the skid holds a word and falls the cycle after it drains.
// Reset: rst (synchronous) clears all valid flags; no words are in flight
// afterward and the block accepts input on the next cycle.
module cosine_hemisphere_sampler
  import cshs_pkg::*;
#(
  parameter int FRAC_BITS    = 14,
  parameter int RAND_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [NORM_W-1:0] normal_x,
  input  logic signed [NORM_W-1:0] normal_y,
  input  logic signed [NORM_W-1:0] normal_z,
  input  logic [15:0]              rand_radius,
  input  logic [15:0]              rand_angle,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [OUT_W-1:0]  dir_x,
  output logic signed [OUT_W-1:0]  dir_y,
  output logic signed [OUT_W-1:0]  dir_z
);

  localparam int QW       = 2 * FRAC_BITS + 1;
  localparam int SQ_STEPS = FRAC_BITS + 1;
  localparam int NC       = (CORDIC_STEPS > SQ_STEPS) ? CORDIC_STEPS : SQ_STEPS;
  localparam int TURN_SH  = 32 - RAND_BITS;
  localparam int RW       = FRAC_BITS + 1;   // r and h, unsigned
  localparam int CSW      = FRAC_BITS + 3;   // cos, sin, rc, rs
  localparam int RPW      = RW + CSW + 1;    // raw r*cos
  localparam int SUM_W    = FRAC_BITS + 26;

  // round half up then floor, arithmetic
  function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                              input int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // global pipe advance: stop only when the skid holds a word
  logic en;
  logic skid_vld;
  assign en       = !skid_vld;
  assign in_stall = skid_vld;

  // ---------------- frame stage ----------------
  logic signed [NORM_W-1:0] n_in [3];
  logic signed [BIT_W-1:0]  e_in [3];
  logic signed [BIT_W-1:0]  a_in [3];
  logic signed [BIT_W-1:0]  b_in [3];
  logic signed [34:0]       d_in [3];
  logic                     xm, ym;
  frame_t                   fr_in;
  logic [RAND_BITS-1:0]     u1, u2;
  logic [RAND_BITS:0]       hv;
  logic [QW-1:0]            qr, qh;
  logic [31:0]              turn;
  logic [62:0]              zp;

  assign n_in[0] = normal_x;
  assign n_in[1] = normal_y;
  assign n_in[2] = normal_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_in[i] = BIT_W'(n_in[i]);
      a_in[i] = (e_in[i] < 0) ? -e_in[i] : e_in[i];
    end
    // smallest magnitude axis, ties fall to the later axis
    xm = (a_in[0] < a_in[1]) && (a_in[0] < a_in[2]);
    ym = !xm && (a_in[1] < a_in[2]);
    if (xm) begin
      b_in[0] = '0;       b_in[1] = e_in[2];  b_in[2] = -e_in[1];
    end else if (ym) begin
      b_in[0] = -e_in[2]; b_in[1] = '0;       b_in[2] = e_in[0];
    end else begin
      b_in[0] = e_in[1];  b_in[1] = -e_in[0]; b_in[2] = '0;
    end
    d_in[0] = 35'(b_in[1]) * 35'(e_in[2]) - 35'(b_in[2]) * 35'(e_in[1]);
    d_in[1] = 35'(b_in[2]) * 35'(e_in[0]) - 35'(b_in[0]) * 35'(e_in[2]);
    d_in[2] = 35'(b_in[0]) * 35'(e_in[1]) - 35'(b_in[1]) * 35'(e_in[0]);
    for (int i = 0; i < 3; i++) begin
      fr_in.n[i] = n_in[i];
      fr_in.b[i] = b_in[i];
      fr_in.t[i] = TAN_W'(rshr(64'(d_in[i]), FRAC_BITS));
    end
    fr_in.quad = turn[31:30];
  end

  assign u1   = RAND_BITS'(rand_radius);
  assign u2   = RAND_BITS'(rand_angle);
  assign hv   = {1'b1, {RAND_BITS{1'b0}}} - {1'b0, u1};
  assign turn = 32'(u2) << TURN_SH;
  // angle within the quadrant, Q30 turns of a quarter times pi
  assign zp   = 63'(turn[29:0]) * 63'(PI_Q30) + (63'd1 << 30);

  generate
    if (2 * FRAC_BITS >= RAND_BITS) begin : g_up
      assign qr = QW'(u1) << (2 * FRAC_BITS - RAND_BITS);
      assign qh = QW'(hv) << (2 * FRAC_BITS - RAND_BITS);
    end else begin : g_dn
      assign qr = QW'(u1 >> (RAND_BITS - 2 * FRAC_BITS));
      assign qh = QW'(hv >> (RAND_BITS - 2 * FRAC_BITS));
    end
  endgenerate

  // ---------------- cell row ----------------
  logic                 c_vld   [NC+1];
  frame_t               c_frame [NC+1];
  logic signed [CW-1:0] c_x     [NC+1];
  logic signed [CW-1:0] c_y     [NC+1];
  logic signed [CW-1:0] c_z     [NC+1];
  logic [QW-1:0]        c_rv    [NC+1];
  logic [QW-1:0]        c_rr    [NC+1];
  logic [QW-1:0]        c_hv    [NC+1];
  logic [QW-1:0]        c_hr    [NC+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld[0] <= 1'b0;
    end else if (en) begin
      c_vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_frame[0] <= fr_in;
      c_x[0]     <= GAIN_Q30;
      c_y[0]     <= '0;
      c_z[0]     <= CW'({1'b0, zp[62:31]});
      c_rv[0]    <= qr;
      c_rr[0]    <= '0;
      c_hv[0]    <= qh;
      c_hr[0]    <= '0;
    end
  end

  generate
    for (genvar k = 0; k < NC; k++) begin : g_cell
      cshs_cell #(
        .IDX          (k),
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .in_vld    (c_vld[k]),
        .in_frame  (c_frame[k]),
        .in_x      (c_x[k]),
        .in_y      (c_y[k]),
        .in_z      (c_z[k]),
        .in_rv     (c_rv[k]),
        .in_rr     (c_rr[k]),
        .in_hv     (c_hv[k]),
        .in_hr     (c_hr[k]),
        .out_vld   (c_vld[k+1]),
        .out_frame (c_frame[k+1]),
        .out_x     (c_x[k+1]),
        .out_y     (c_y[k+1]),
        .out_z     (c_z[k+1]),
        .out_rv    (c_rv[k+1]),
        .out_rr    (c_rr[k+1]),
        .out_hv    (c_hv[k+1]),
        .out_hr    (c_hr[k+1])
      );
    end
  endgenerate

  // ---------------- combine stages ----------------
  logic                  p1_vld, p2_vld, p3_vld, p4_vld;
  frame_t                p1_frame, p2_frame, p3_frame;
  logic signed [CSW-1:0] p1_c, p1_s;
  logic [RW-1:0]         p1_r, p1_h, p2_h;
  logic signed [RPW-1:0] p2_rc, p2_rs;
  logic signed [SUM_W-1:0] p3_pt [3];
  logic signed [SUM_W-1:0] p3_pb [3];
  logic signed [SUM_W-1:0] p3_pn [3];
  logic signed [OUT_W-1:0] p4_dir [3];

  logic signed [CW-1:0]    cq, sq;
  logic signed [CSW-1:0]   rc, rs;
  logic signed [SUM_W-1:0] sum [3];
  logic signed [63:0]      rv  [3];
  logic signed [63:0]      sv  [3];

  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

  always_comb begin
    case (c_frame[NC].quad)
      2'd0:    begin cq = c_x[NC];  sq = c_y[NC];  end
      2'd1:    begin cq = -c_y[NC]; sq = c_x[NC];  end
      2'd2:    begin cq = -c_x[NC]; sq = -c_y[NC]; end
      default: begin cq = c_y[NC];  sq = -c_x[NC]; end
    endcase
    rc = CSW'(rshr(64'(p2_rc), FRAC_BITS));
    rs = CSW'(rshr(64'(p2_rs), FRAC_BITS));
    for (int i = 0; i < 3; i++) begin
      sum[i] = p3_pt[i] + p3_pb[i] + p3_pn[i];
      rv[i]  = rshr(64'(sum[i]), FRAC_BITS);
      sv[i]  = rv[i];
      if (sv[i] > ONE) sv[i] = ONE;
      if (sv[i] < -ONE) sv[i] = -ONE;
      if (sv[i] > 64'sd32767) sv[i] = 64'sd32767;
      if (sv[i] < -64'sd32768) sv[i] = -64'sd32768;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      p4_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= c_vld[NC];
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      p4_vld <= p3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // quadrant fold and rounding to Q.FRAC_BITS
      p1_frame <= c_frame[NC];
      p1_c     <= CSW'(rshr(64'(cq), 30 - FRAC_BITS));
      p1_s     <= CSW'(rshr(64'(sq), 30 - FRAC_BITS));
      p1_r     <= c_rr[NC][RW-1:0];
      p1_h     <= c_hr[NC][RW-1:0];
      // radius times cos / sin
      p2_frame <= p1_frame;
      p2_h     <= p1_h;
      p2_rc    <= RPW'($signed({1'b0, p1_r})) * RPW'(p1_c);
      p2_rs    <= RPW'($signed({1'b0, p1_r})) * RPW'(p1_s);
      // basis products
      p3_frame <= p2_frame;
      for (int i = 0; i < 3; i++) begin
        p3_pt[i] <= SUM_W'($signed(p2_frame.t[i])) * SUM_W'(rc);
        p3_pb[i] <= SUM_W'($signed(p2_frame.b[i])) * SUM_W'(rs);
        p3_pn[i] <= SUM_W'($signed(p2_frame.n[i])) * SUM_W'($signed({1'b0, p2_h}));
      end
      // sum, round, saturate
      for (int i = 0; i < 3; i++) begin
        p4_dir[i] <= OUT_W'(sv[i]);
      end
    end
  end

  // ---------------- output register and skid ----------------
  logic                    take, new_word;
  logic signed [OUT_W-1:0] skid_dir [3];

  assign take     = out_valid && !out_stall;
  assign new_word = p4_vld && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (!out_valid || take) begin
      out_valid <= skid_vld || new_word;
      skid_vld  <= 1'b0;
    end else if (new_word) begin
      skid_vld  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_vld) begin
        dir_x <= skid_dir[0];
        dir_y <= skid_dir[1];
        dir_z <= skid_dir[2];
      end else begin
        dir_x <= p4_dir[0];
        dir_y <= p4_dir[1];
        dir_z <= p4_dir[2];
      end
    end else if (new_word) begin
      skid_dir <= p4_dir;
    end
  end

  // skid holds a word only behind a held output word
  assert property (@(posedge clk) disable iff (rst) skid_vld |-> out_valid)
    else $error("skid full with output register empty");

  // a waiting skid word is not dropped while the receiver stalls
  assert property (@(posedge clk) disable iff (rst)
    (skid_vld && out_stall) |=> skid_vld)
    else $error("skid word lost under stall");

  // output drains when nothing is behind it
  assert property (@(posedge clk) disable iff (rst)
    (take && !skid_vld && !p4_vld) |=> !out_valid)
    else $error("output word invented");

  // reset leaves no word in flight at the output
  assert property (@(posedge clk) rst |=> (!out_valid && !skid_vld))
    else $error("output valid after reset");

endmodule

[bench/cosine_hemisphere_checker.sv]
`timescale 1ns / 1ps
module cosine_hemisphere_checker
  import cshs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [NORM_W-1:0] normal_x,
  input  logic signed [NORM_W-1:0] normal_y,
  input  logic signed [NORM_W-1:0] normal_z,
  input  logic [15:0]              rand_radius,
  input  logic [15:0]              rand_angle,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [OUT_W-1:0]  dir_x,
  input  logic signed [OUT_W-1:0]  dir_y,
  input  logic signed [OUT_W-1:0]  dir_z,
  output int                       fail_count,
  output int                       dirs_pending,
  output int                       dirs_seen
);

  localparam int FB = 14;
  localparam int RB = 16;
  localparam int STEPS = 16;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } dir_t;

  dir_t dir_queue[$];

  function automatic longint floor_div2(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_div2(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint res, bit_v;
    res = 0;
    bit_v = longint'(1) << 62;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp_unit(longint v);
    longint one;
    one = longint'(1) << FB;
    if (v > one) v = one;
    if (v < -one) v = -one;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic dir_t sample_dir(logic signed [15:0] nx, logic signed [15:0] ny,
                                      logic signed [15:0] nz, logic [15:0] u1_raw,
                                      logic [15:0] u2_raw);
    longint n[3], a[3], b[3], t[3];
    longint r, h, z, x, y, dx, dy, c, s, rc, rs, sum;
    logic [31:0] turn;
    logic [1:0] quad;
    bit xm, ym;
    dir_t d;
    n[0] = nx; n[1] = ny; n[2] = nz;
    for (int i = 0; i < 3; i++) a[i] = n[i] < 0 ? -n[i] : n[i];
    xm = a[0] < a[1] && a[0] < a[2];
    ym = !xm && a[1] < a[2];
    if (xm) begin
      b[0] = 0; b[1] = n[2]; b[2] = -n[1];
    end else if (ym) begin
      b[0] = -n[2]; b[1] = 0; b[2] = n[0];
    end else begin
      b[0] = n[1]; b[1] = -n[0]; b[2] = 0;
    end
    t[0] = round_div2(b[1] * n[2] - b[2] * n[1], FB);
    t[1] = round_div2(b[2] * n[0] - b[0] * n[2], FB);
    t[2] = round_div2(b[0] * n[1] - b[1] * n[0], FB);
    // Q28 fractions: shift 16-bit fraction up by 12
    r = int_sqrt(longint'(u1_raw) << (2 * FB - RB));
    h = int_sqrt((longint'(65536) - longint'(u1_raw)) << (2 * FB - RB));
    turn = {u2_raw, 16'h0};
    quad = turn[31:30];
    z = (longint'(turn[29:0]) * longint'(PI_Q30) + (longint'(1) << 30)) >>> 31;
    x = longint'(GAIN_Q30);
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = floor_div2(y, i);
      dy = floor_div2(x, i);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(atan_q30(i));
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(atan_q30(i));
      end
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c = round_div2(c, 30 - FB);
    s = round_div2(s, 30 - FB);
    rc = round_div2(r * c, FB);
    rs = round_div2(r * s, FB);
    sum = t[0] * rc + b[0] * rs + n[0] * h;
    d.x = 16'(clamp_unit(round_div2(sum, FB)));
    sum = t[1] * rc + b[1] * rs + n[1] * h;
    d.y = 16'(clamp_unit(round_div2(sum, FB)));
    sum = t[2] * rc + b[2] * rs + n[2] * h;
    d.z = 16'(clamp_unit(round_div2(sum, FB)));
    return d;
  endfunction

  always @(posedge clk) begin
    dir_t want;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
      dirs_seen <= 0;
      dirs_pending <= 0;
    end else begin
      if (in_valid && !in_stall)
        dir_queue.insert(dir_queue.size(),
                         sample_dir(normal_x, normal_y, normal_z, rand_radius, rand_angle));
      if (out_valid && !out_stall) begin
        dirs_seen <= dirs_seen + 1;
        if (dir_queue.size() == 0) begin
          $error("unexpected direction word %0d %0d %0d", dir_x, dir_y, dir_z);
          errs++;
        end else begin
          want = dir_queue.pop_front();
          if (dir_x !== want.x) begin
            $error("dir_x expected %0d actual %0d", want.x, dir_x);
            errs++;
          end
          if (dir_y !== want.y) begin
            $error("dir_y expected %0d actual %0d", want.y, dir_y);
            errs++;
          end
          if (dir_z !== want.z) begin
            $error("dir_z expected %0d actual %0d", want.z, dir_z);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      dirs_pending <= dir_queue.size();
    end
  end

endmodule

[bench/cosine_hemisphere_sampler_tb.sv]
`timescale 1ns / 1ps
module cosine_hemisphere_sampler_tb;
  import cshs_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [NORM_W-1:0] normal_x = '0;
  logic signed [NORM_W-1:0] normal_y = '0;
  logic signed [NORM_W-1:0] normal_z = '0;
  logic [15:0] rand_radius = '0;
  logic [15:0] rand_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] dir_x, dir_y, dir_z;
  int fail_count, dirs_pending, dirs_seen;

  // receiver behavior: 0 random, 1 never stall, 2 long hold-off
  int sink_mode = 0;
  int words_sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cosine_hemisphere_sampler DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .rand_radius(rand_radius), .rand_angle(rand_angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z)
  );

  cosine_hemisphere_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .rand_radius(rand_radius), .rand_angle(rand_angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .fail_count(fail_count), .dirs_pending(dirs_pending), .dirs_seen(dirs_seen)
  );

  // Receiver: random stalls about a quarter of the time, a clean stretch,
  // and one long hold-off so the pipe and skid fill and in_stall rises.
  always @(posedge clk) begin
    if (rst || sink_mode == 1) out_stall <= 1'b0;
    else if (sink_mode == 2) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < 25);
  end

  initial begin
    // hold off once the random stream is running
    wait (words_sent >= 100);
    @(posedge clk);
    sink_mode = 2;
    repeat (80) @(posedge clk);   // long hold-off, sender keeps pushing
    sink_mode = 0;
    repeat (400) @(posedge clk);
    sink_mode = 1;                // clean stretch
    repeat (300) @(posedge clk);
    sink_mode = 0;
  end

  // Hands one word to the block; holds it steady until accepted.
  // Gaps are random unless no_gap is set.
  task automatic send_word(input logic [15:0] nx, input logic [15:0] ny,
                           input logic [15:0] nz, input logic [15:0] u1,
                           input logic [15:0] u2, input bit no_gap);
    if (!no_gap) begin
      while ($urandom_range(99) < 25) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    normal_x <= nx;
    normal_y <= ny;
    normal_z <= nz;
    rand_radius <= u1;
    rand_angle <= u2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Random normal: one dominant component in six of ten, else wider or any bit pattern.
  task automatic send_random(input bit no_gap);
    logic [15:0] c[3];
    int kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      if (kind < 6) c[i] = 16'($signed($urandom_range(18000)) - 9000);
      else if (kind < 8) c[i] = 16'($signed($urandom_range(32768)) - 16384);
      else c[i] = 16'($urandom);  // any bit pattern, off-unit normals
    end
    if (kind < 6) c[$urandom_range(2)] = ($urandom_range(1) != 0) ? 16'd15000 : -16'sd15000;
    send_word(c[0], c[1], c[2], 16'($urandom), 16'($urandom), no_gap);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: unit axes, zero and most negative normals, ties, root ends
    send_word(16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_word(16'd0, 16'd16384, 16'd0, 16'd65535, 16'd16384, 1'b0);
    send_word(16'd0, 16'd0, 16'd16384, 16'd32768, 16'd32768, 1'b0);
    send_word(-16'sd16384, 16'd0, 16'd0, 16'd1, 16'd49152, 1'b0);
    send_word(16'd0, -16'sd16384, 16'd0, 16'd65535, 16'd65535, 1'b0);
    send_word(16'd0, 16'd0, -16'sd16384, 16'd12345, 16'd1, 1'b0);
    send_word(16'd0, 16'd0, 16'd0, 16'd40000, 16'd20000, 1'b0);
    send_word(16'h8000, 16'h8000, 16'h8000, 16'd0, 16'd0, 1'b0);
    send_word(16'h8000, 16'h7fff, 16'd0, 16'd65535, 16'd65535, 1'b0);
    send_word(16'h7fff, 16'h7fff, 16'h7fff, 16'd30000, 16'd8000, 1'b0);
    send_word(16'd9459, 16'd9459, 16'd9459, 16'd50000, 16'd16383, 1'b0);
    send_word(16'd9459, -16'sd9459, 16'd9459, 16'd50000, 16'd32767, 1'b0);
    send_word(16'd5000, 16'd5000, 16'd14000, 16'd20000, 16'd49151, 1'b0);
    send_word(16'd14000, 16'd5000, 16'd5000, 16'd20000, 16'd100, 1'b0);
    send_word(16'd3000, 16'd8000, 16'd13000, 16'hffff, 16'hffff, 1'b0);
    send_word(16'd8000, 16'd3000, 16'd13000, 16'haaaa, 16'h5555, 1'b0);
    send_word(16'hffff, 16'h0001, 16'hfffe, 16'h5555, 16'haaaa, 1'b0);

    // sender pause: wait for every direction to come back
    in_valid <= 1'b0;
    @(posedge clk);
    while (dirs_pending != 0) @(posedge clk);

    // words 300 to 499 go back to back with no idling
    for (int k = 0; k < 800; k++) send_random(k >= 300 && k < 500);
    in_valid <= 1'b0;

    @(posedge clk);
    while (dirs_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d sample words, checked %0d directions (axes, ties, saturation).",
             words_sent, dirs_seen);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
